// ===== src/spa_pkg.sv =====
// shared types and constants for the sparse polynomial arithmetic block
`default_nettype none

package spa_pkg;

   localparam int MAX_TERMS   = 8;
   localparam int IDX_W       = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT_W       = $clog2(MAX_TERMS + 1);
   localparam int PROD_DEPTH  = MAX_TERMS * MAX_TERMS;
   localparam int PADDR_W     = (PROD_DEPTH > 1) ? $clog2(PROD_DEPTH) : 1;
   localparam int PCNT_W      = $clog2(PROD_DEPTH + 1);

   localparam int OP_W        = 3;
   localparam int COEF_W      = 16;
   localparam int POWER_W     = 8;
   localparam int RES_COEF_W  = 40;
   localparam int RES_POWER_W = 9;

   localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD_SECOND = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD         = 3'd2;
   localparam logic [OP_W-1:0] OP_SUB         = 3'd3;
   localparam logic [OP_W-1:0] OP_MUL         = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR       = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic signed [COEF_W-1:0]  term_coef;
      logic [POWER_W-1:0]        term_power;
   } req_type;

   typedef struct packed {
      logic signed [RES_COEF_W-1:0] res_coef;
      logic [RES_POWER_W-1:0]       res_power;
      logic                         last;
      logic                         none;
   } rsp_type;

   typedef struct packed {
      logic signed [RES_COEF_W-1:0] coef;
      logic [RES_POWER_W-1:0]       power;
   } prod_entry_type;

   typedef struct packed {
      logic                 en;
      logic [PADDR_W-1:0]   addr;
      prod_entry_type       data;
   } prod_wr_type;

endpackage

`default_nettype wire

// ===== src/spa_prod_ram.sv =====
// product term store: one write port, one registered read port
`default_nettype none

module spa_prod_ram (
   input  logic                          clock,
   input  spa_pkg::prod_wr_type          wr,
   input  logic [spa_pkg::PADDR_W-1:0]   rd_addr,
   output spa_pkg::prod_entry_type       rd_data
);
   import spa_pkg::*;

   prod_entry_type mem [PROD_DEPTH];
   prod_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/sparse_polynomial_arithmetic.sv =====
// top level of the sparse polynomial add, subtract and multiply block
// usage:
//  - req channel takes one command word per handshake: load a term into the first or
//    second list, add, subtract, multiply or clear both lists
//  - loads and clear give no rsp word; a load into a full list is dropped
//  - add and subtract walk both lists with two pointers, one rsp word per cycle while
//    rsp_stall is low
//  - multiply runs each term pair through the multiplier and scans the product store
//    for a matching power (S_SCAN, S_CMP per entry), then reads out each word through
//    S_EMIT_RD and S_EMIT_WR
//  - req_stall is high for the whole of a compute command
//  - every rsp word sits in an output register; the next command is taken while the
//    last word of a result still waits there
//  - an empty result gives one word with none and last set
//  - rsp_stall simply holds a pending word in the output register and freezes the walk or read-out
//  - synchronous reset empties both lists and drops any pending rsp word; no clearing
//    pass is needed, stored terms past the counts are never read
`default_nettype none

module sparse_polynomial_arithmetic (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  spa_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output spa_pkg::rsp_type   rsp_data
);
   import spa_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MERGE,
      S_MUL,
      S_SCAN,
      S_CMP,
      S_EMIT_RD,
      S_EMIT_WR
   } state_type;

   // control registers
   state_type               state_ff,     state_in;
   logic [CNT_W-1:0]        first_cnt_ff, first_cnt_in;
   logic [CNT_W-1:0]        second_cnt_ff, second_cnt_in;
   logic [CNT_W-1:0]        a_ff,         a_in;
   logic [CNT_W-1:0]        b_ff,         b_in;
   logic [PCNT_W-1:0]       m_ff,         m_in;
   logic [PCNT_W-1:0]       n_ff,         n_in;
   logic                    sub_ff,       sub_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic signed [COEF_W-1:0]     first_coef_ff   [MAX_TERMS];
   logic signed [COEF_W-1:0]     first_coef_in   [MAX_TERMS];
   logic [POWER_W-1:0]           first_power_ff  [MAX_TERMS];
   logic [POWER_W-1:0]           first_power_in  [MAX_TERMS];
   logic signed [COEF_W-1:0]     second_coef_ff  [MAX_TERMS];
   logic signed [COEF_W-1:0]     second_coef_in  [MAX_TERMS];
   logic [POWER_W-1:0]           second_power_ff [MAX_TERMS];
   logic [POWER_W-1:0]           second_power_in [MAX_TERMS];
   logic signed [RES_COEF_W-1:0] prod_ff,        prod_in;
   logic [RES_POWER_W-1:0]       pow_ff,         pow_in;
   rsp_type                      rsp_ff,         rsp_in;

   // product store
   prod_wr_type                  prod_wr;
   prod_entry_type               prod_rd;

   // datapath
   logic                         accept;
   logic                         out_free;
   logic signed [COEF_W-1:0]     fa_coef;
   logic [POWER_W-1:0]           fa_power;
   logic signed [COEF_W-1:0]     sb_coef;
   logic [POWER_W-1:0]           sb_power;
   logic signed [RES_COEF_W-1:0] ca_ext;
   logic signed [RES_COEF_W-1:0] cb_ext;
   logic signed [RES_COEF_W-1:0] cb_sel;
   logic signed [2*COEF_W-1:0]   mul_full;
   logic                         a_live;
   logic                         b_live;
   logic                         take_a;
   logic                         take_b;
   logic [CNT_W-1:0]             a_next;
   logic [CNT_W-1:0]             b_next;
   logic                         merge_done;
   logic signed [RES_COEF_W-1:0] merge_coef;
   logic [RES_POWER_W-1:0]       merge_power;
   logic                         pair_last_b;
   logic                         pair_last;
   logic [PCNT_W-1:0]            m_next;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // one read index per list, shared by the merge walk and the pair loop
   assign fa_coef  = first_coef_ff[a_ff[IDX_W-1:0]];
   assign fa_power = first_power_ff[a_ff[IDX_W-1:0]];
   assign sb_coef  = second_coef_ff[b_ff[IDX_W-1:0]];
   assign sb_power = second_power_ff[b_ff[IDX_W-1:0]];

   assign ca_ext   = RES_COEF_W'(fa_coef);
   assign cb_ext   = RES_COEF_W'(sb_coef);
   assign cb_sel   = sub_ff ? -cb_ext : cb_ext;
   assign mul_full = fa_coef * sb_coef;

   // two-pointer choice for add and subtract
   assign a_live = (a_ff < first_cnt_ff);
   assign b_live = (b_ff < second_cnt_ff);

   always_comb begin
      take_a      = 1'b0;
      take_b      = 1'b0;
      merge_coef  = cb_sel;
      merge_power = {1'b0, sb_power};
      priority if (a_live && b_live && (fa_power == sb_power)) begin
         take_a     = 1'b1;
         take_b     = 1'b1;
         merge_coef = ca_ext + cb_sel;
         merge_power = {1'b0, fa_power};
      end else if (a_live && (!b_live || (fa_power > sb_power))) begin
         take_a      = 1'b1;
         merge_coef  = ca_ext;
         merge_power = {1'b0, fa_power};
      end else begin
         take_b = b_live;
      end
   end

   assign a_next     = a_ff + CNT_W'(take_a);
   assign b_next     = b_ff + CNT_W'(take_b);
   assign merge_done = !(a_next < first_cnt_ff) && !(b_next < second_cnt_ff);

   // pair loop: first list outer, second list inner
   assign pair_last_b = ((b_ff + CNT_W'(1)) == second_cnt_ff);
   assign pair_last   = pair_last_b && ((a_ff + CNT_W'(1)) == first_cnt_ff);
   assign m_next      = m_ff + PCNT_W'(1);

   always_comb begin
      state_in        = state_ff;
      first_cnt_in    = first_cnt_ff;
      second_cnt_in   = second_cnt_ff;
      a_in            = a_ff;
      b_in            = b_ff;
      m_in            = m_ff;
      n_in            = n_ff;
      sub_in          = sub_ff;
      first_coef_in   = first_coef_ff;
      first_power_in  = first_power_ff;
      second_coef_in  = second_coef_ff;
      second_power_in = second_power_ff;
      prod_in         = prod_ff;
      pow_in          = pow_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      prod_wr         = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.op)
                  OP_LOAD_FIRST: begin
                     if (first_cnt_ff < CNT_W'(MAX_TERMS)) begin
                        first_coef_in[first_cnt_ff[IDX_W-1:0]]  = req_data.term_coef;
                        first_power_in[first_cnt_ff[IDX_W-1:0]] = req_data.term_power;
                        first_cnt_in = first_cnt_ff + CNT_W'(1);
                     end
                  end
                  OP_LOAD_SECOND: begin
                     if (second_cnt_ff < CNT_W'(MAX_TERMS)) begin
                        second_coef_in[second_cnt_ff[IDX_W-1:0]]  = req_data.term_coef;
                        second_power_in[second_cnt_ff[IDX_W-1:0]] = req_data.term_power;
                        second_cnt_in = second_cnt_ff + CNT_W'(1);
                     end
                  end
                  OP_ADD, OP_SUB: begin
                     a_in     = '0;
                     b_in     = '0;
                     sub_in   = (req_data.op == OP_SUB);
                     state_in = S_MERGE;
                  end
                  OP_MUL: begin
                     a_in = '0;
                     b_in = '0;
                     m_in = '0;
                     n_in = '0;
                     if ((first_cnt_ff == '0) || (second_cnt_ff == '0)) begin
                        state_in = S_EMIT_RD;
                     end else begin
                        state_in = S_MUL;
                     end
                  end
                  OP_CLEAR: begin
                     first_cnt_in  = '0;
                     second_cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_MERGE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (!a_live && !b_live) begin
                  rsp_in   = '{res_coef: '0, res_power: '0, last: 1'b1, none: 1'b1};
                  state_in = S_IDLE;
               end else begin
                  rsp_in = '{res_coef: merge_coef, res_power: merge_power,
                             last: merge_done, none: 1'b0};
                  a_in   = a_next;
                  b_in   = b_next;
                  if (merge_done) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end

         S_MUL: begin
            prod_in  = RES_COEF_W'(mul_full);
            pow_in   = {1'b0, fa_power} + {1'b0, sb_power};
            m_in     = '0;
            state_in = S_SCAN;
         end

         S_SCAN, S_CMP: begin
            if ((state_ff == S_SCAN) && (m_ff != n_ff)) begin
               state_in = S_CMP;
            end else if ((state_ff == S_CMP) && (prod_rd.power != pow_ff)) begin
               m_in     = m_next;
               state_in = S_SCAN;
            end else begin
               // fold into a matching entry, or append a new power at the end
               if (state_ff == S_CMP) begin
                  prod_wr.en         = 1'b1;
                  prod_wr.addr       = m_ff[PADDR_W-1:0];
                  prod_wr.data.coef  = prod_rd.coef + prod_ff;
                  prod_wr.data.power = pow_ff;
               end else if (n_ff < PCNT_W'(PROD_DEPTH)) begin
                  prod_wr.en         = 1'b1;
                  prod_wr.addr       = n_ff[PADDR_W-1:0];
                  prod_wr.data.coef  = prod_ff;
                  prod_wr.data.power = pow_ff;
                  n_in               = n_ff + PCNT_W'(1);
               end
               m_in = '0;
               if (pair_last) begin
                  state_in = S_EMIT_RD;
               end else if (pair_last_b) begin
                  a_in     = a_ff + CNT_W'(1);
                  b_in     = '0;
                  state_in = S_MUL;
               end else begin
                  b_in     = b_ff + CNT_W'(1);
                  state_in = S_MUL;
               end
            end
         end

         S_EMIT_RD: begin
            state_in = S_EMIT_WR;
         end

         S_EMIT_WR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (n_ff == '0) begin
                  rsp_in   = '{res_coef: '0, res_power: '0, last: 1'b1, none: 1'b1};
                  state_in = S_IDLE;
               end else begin
                  rsp_in = '{res_coef: prod_rd.coef, res_power: prod_rd.power,
                             last: (m_next == n_ff), none: 1'b0};
                  m_in   = m_next;
                  if (m_next == n_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_EMIT_RD;
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         first_cnt_ff  <= '0;
         second_cnt_ff <= '0;
         a_ff          <= '0;
         b_ff          <= '0;
         m_ff          <= '0;
         n_ff          <= '0;
         sub_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_cnt_ff  <= first_cnt_in;
         second_cnt_ff <= second_cnt_in;
         a_ff          <= a_in;
         b_ff          <= b_in;
         m_ff          <= m_in;
         n_ff          <= n_in;
         sub_ff        <= sub_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      first_coef_ff   <= first_coef_in;
      first_power_ff  <= first_power_in;
      second_coef_ff  <= second_coef_in;
      second_power_ff <= second_power_in;
      prod_ff         <= prod_in;
      pow_ff          <= pow_in;
      rsp_ff          <= rsp_in;
   end

   spa_prod_ram u_prod_ram (
      .clock   (clock),
      .wr      (prod_wr),
      .rd_addr (m_ff[PADDR_W-1:0]),
      .rd_data (prod_rd)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // list fill never passes capacity
   a_list_bound: assert property (@(posedge clock) disable iff (reset)
      (first_cnt_ff <= CNT_W'(MAX_TERMS)) && (second_cnt_ff <= CNT_W'(MAX_TERMS)))
      else $error("term list count beyond capacity");

   // the store scan never runs past the filled entries
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) || (state_ff == S_CMP)) |-> (m_ff <= n_ff) &&
      (n_ff <= PCNT_W'(PROD_DEPTH)))
      else $error("product scan index beyond store fill");

   // an empty-result word always closes its result
   a_none_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.none) |-> rsp_ff.last)
      else $error("empty-result word without last");

   // a stalled output word is never overwritten by the walk
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("pending rsp word overwritten");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/sparse_polynomial_arithmetic_tb.sv =====
// self-checking testbench for the sparse polynomial add, subtract and multiply block
`timescale 1ns / 100ps

module sparse_polynomial_arithmetic_tb;
   import spa_pkg::*;

   // op codes the block must ignore
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   localparam int ITEM_TARGET  = 250;       // counted command words, ignored codes excluded
   localparam int QUIET_ITEMS  = 40;        // closing stretch with no idling on either side
   localparam int TAIL_CYCLES  = 3000;      // idle tail after every result has drained
   localparam int CYCLE_LIMIT  = 10000000;

   typedef logic signed [RES_COEF_W-1:0] wide_coef_type;

   // expected result words, built from an independent model of both term lists
   class polynomial_scoreboard;
      logic signed [COEF_W-1:0] first_coef   [MAX_TERMS];
      logic [POWER_W-1:0]       first_power  [MAX_TERMS];
      int                       first_len;
      logic signed [COEF_W-1:0] second_coef  [MAX_TERMS];
      logic [POWER_W-1:0]       second_power [MAX_TERMS];
      int                       second_len;
      rsp_type                  expected_terms [$];

      int unsigned error_count, word_count, empty_count;
      int unsigned load_count, dropped_count, clear_count, ignored_count;
      int unsigned add_count, sub_count, mul_count;

      task report(string what);
         error_count++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      function void push_term(wide_coef_type coef, logic [RES_POWER_W-1:0] power);
         rsp_type t;
         t.res_coef  = coef;
         t.res_power = power;
         t.last      = 1'b0;
         t.none      = 1'b0;
         expected_terms.push_back(t);
      endfunction

      // mark the final word, or stand in a single empty word
      function void close_result(int produced);
         rsp_type t;
         if (produced == 0) begin
            t = '0;
            t.last = 1'b1;
            t.none = 1'b1;
            empty_count++;
         end else begin
            t = expected_terms.pop_back();
            t.last = 1'b1;
         end
         expected_terms.push_back(t);
      endfunction

      function wide_coef_type second_term(int b, bit negate);
         wide_coef_type c;
         c = second_coef[b];
         if (negate)
            c = -c;
         return c;
      endfunction

      // two-pointer walk, whatever order the powers were loaded in
      function void merge_lists(bit negate);
         int            a, b, produced;
         wide_coef_type ca, cb;
         a = 0;
         b = 0;
         produced = 0;
         while (a < first_len && b < second_len) begin
            ca = first_coef[a];
            cb = second_term(b, negate);
            if (first_power[a] == second_power[b]) begin
               push_term(ca + cb, {1'b0, first_power[a]});
               a++;
               b++;
            end else if (first_power[a] > second_power[b]) begin
               push_term(ca, {1'b0, first_power[a]});
               a++;
            end else begin
               push_term(cb, {1'b0, second_power[b]});
               b++;
            end
            produced++;
         end
         while (a < first_len) begin
            ca = first_coef[a];
            push_term(ca, {1'b0, first_power[a]});
            a++;
            produced++;
         end
         while (b < second_len) begin
            push_term(second_term(b, negate), {1'b0, second_power[b]});
            b++;
            produced++;
         end
         close_result(produced);
      endfunction

      // outer first, inner second; a repeated power folds into its first slot
      function void multiply_lists();
         wide_coef_type            sum_coef  [$];
         logic [RES_POWER_W-1:0]   sum_power [$];
         wide_coef_type            ca, cb, c;
         logic [RES_POWER_W-1:0]   p;
         int                       slot;
         for (int i = 0; i < first_len; i++) begin
            for (int j = 0; j < second_len; j++) begin
               ca = first_coef[i];
               cb = second_coef[j];
               c  = ca * cb;
               p  = first_power[i] + second_power[j];
               slot = -1;
               foreach (sum_power[m])
                  if (slot < 0 && sum_power[m] == p)
                     slot = m;
               if (slot >= 0) begin
                  sum_coef[slot] = sum_coef[slot] + c;
               end else begin
                  sum_coef.push_back(c);
                  sum_power.push_back(p);
               end
            end
         end
         foreach (sum_coef[m])
            push_term(sum_coef[m], sum_power[m]);
         close_result(sum_coef.size());
      endfunction

      function void note_request(req_type w);
         case (w.op)
            OP_LOAD_FIRST: begin
               load_count++;
               if (first_len < MAX_TERMS) begin
                  first_coef[first_len]  = w.term_coef;
                  first_power[first_len] = w.term_power;
                  first_len++;
               end else begin
                  dropped_count++;
               end
            end
            OP_LOAD_SECOND: begin
               load_count++;
               if (second_len < MAX_TERMS) begin
                  second_coef[second_len]  = w.term_coef;
                  second_power[second_len] = w.term_power;
                  second_len++;
               end else begin
                  dropped_count++;
               end
            end
            OP_ADD: begin
               add_count++;
               merge_lists(1'b0);
            end
            OP_SUB: begin
               sub_count++;
               merge_lists(1'b1);
            end
            OP_MUL: begin
               mul_count++;
               multiply_lists();
            end
            OP_CLEAR: begin
               clear_count++;
               first_len  = 0;
               second_len = 0;
            end
            default: begin
               ignored_count++;
            end
         endcase
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         word_count++;
         if (expected_terms.size() == 0) begin
            report($sformatf("word with nothing expected: coef %0d power %0d last %0b none %0b",
                             got.res_coef, got.res_power, got.last, got.none));
         end else begin
            want = expected_terms.pop_front();
            if (got.res_coef !== want.res_coef)
               report($sformatf("res_coef %0d, wanted %0d", got.res_coef, want.res_coef));
            if (got.res_power !== want.res_power)
               report($sformatf("res_power %0d, wanted %0d", got.res_power, want.res_power));
            if (got.last !== want.last)
               report($sformatf("last %0b, wanted %0b", got.last, want.last));
            if (got.none !== want.none)
               report($sformatf("none %0b, wanted %0b", got.none, want.none));
         end
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   polynomial_scoreboard sb = new();

   bit          gappy       = 1'b1;   // sender may idle in this stretch
   bit          quiet       = 1'b0;   // closing stretch, no idling at all
   int          sent_items  = 0;
   int unsigned cycle_count = 0;

   sparse_polynomial_arithmetic u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // watchdog against a hung handshake or a missing word
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timed out after %0d cycles, %0d words still outstanding",
               cycle_count, sb.expected_terms.size());
      $display("Verification failed");
      $finish;
   end

   // every word taken on the result side is checked at the edge that takes it
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_data);
   end

   // receiver: random stall bursts between free stretches, none at the close
   initial begin : stall_gen
      int  span_len;
      bit  hold;
      forever begin
         hold     = !quiet && ($urandom_range(0, 2) == 0);
         span_len = hold ? $urandom_range(1, 14) : $urandom_range(1, 40);
         rsp_stall <= hold;
         repeat (span_len) @(posedge clock);
      end
   end

   function automatic req_type command_word(logic [OP_W-1:0] op,
                                            logic signed [COEF_W-1:0] coef,
                                            logic [POWER_W-1:0] power);
      req_type w;
      w.op         = op;
      w.term_coef  = coef;
      w.term_power = power;
      return w;
   endfunction

   // extremes and small values turn up often, the rest is spread over the whole range
   function automatic logic signed [COEF_W-1:0] random_coef();
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return '0;
         3:       return 16'($urandom_range(0, 6)) - 16'd3;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [POWER_W-1:0] random_power(int span);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 8'(span);
         default: return 8'($urandom_range(0, span));
      endcase
   endfunction

   // mostly short lists, now and then full or overflowing
   function automatic int list_size();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return $urandom_range(MAX_TERMS, MAX_TERMS + 2);
         default: return $urandom_range(1, 4);
      endcase
   endfunction

   // drive one word and hold it until taken; an idle burst may come first
   task automatic send_command(req_type w);
      if (gappy && !quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(w);
      if (w.op <= OP_CLEAR)
         sent_items++;
   endtask

   // sender holds off until every expected word has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_terms.size() != 0);
   endtask

   initial begin : stimulus
      logic [POWER_W-1:0] first_plan  [$];
      logic [POWER_W-1:0] second_plan [$];
      logic [OP_W-1:0]    op_pick;
      int                 n_first, n_second, n_ops, span;
      bit                 sorted_order;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty lists give a single empty word
      send_command(command_word(OP_ADD, '0, '0));
      send_command(command_word(OP_MUL, '0, '0));
      // coefficient and power extremes, a zero coefficient, a matching top power
      send_command(command_word(OP_LOAD_FIRST,  16'h7FFF, 8'd255));
      send_command(command_word(OP_LOAD_FIRST,  16'h8000, 8'd0));
      send_command(command_word(OP_LOAD_SECOND, 16'h8000, 8'd255));
      send_command(command_word(OP_LOAD_SECOND, 16'hFFFF, 8'd128));
      send_command(command_word(OP_LOAD_SECOND, 16'h0000, 8'd0));
      send_command(command_word(OP_ADD, '0, '0));
      send_command(command_word(OP_SUB, '0, '0));
      send_command(command_word(OP_MUL, '0, '0));
      // unused codes must leave the lists alone
      send_command(command_word(OP_UNUSED_LO, 16'hFFFF, 8'hFF));
      send_command(command_word(OP_UNUSED_HI, 16'h5A5A, 8'hA5));
      send_command(command_word(OP_ADD, '0, '0));
      // clear, then empty result again
      send_command(command_word(OP_CLEAR, 16'hFFFF, 8'hFF));
      send_command(command_word(OP_SUB, '0, '0));
      // one list empty: product is empty, sum is the other list
      send_command(command_word(OP_LOAD_FIRST, 16'd1, 8'd7));
      send_command(command_word(OP_MUL, '0, '0));
      send_command(command_word(OP_ADD, '0, '0));
      // second list loaded in rising order
      send_command(command_word(OP_LOAD_SECOND, 16'd5, 8'd7));
      send_command(command_word(OP_LOAD_SECOND, 16'd3, 8'd200));
      send_command(command_word(OP_SUB, '0, '0));
      send_command(command_word(OP_MUL, '0, '0));
      drain_results();

      // random: mostly clear, load both lists, compute; some stale lists and noise
      while (sent_items < ITEM_TARGET) begin
         quiet = (sent_items >= ITEM_TARGET - QUIET_ITEMS);
         gappy = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 7) != 0)
            send_command(command_word(OP_CLEAR, random_coef(), random_power(255)));

         n_first      = list_size();
         n_second     = list_size();
         span         = ($urandom_range(0, 1) == 0) ? 15 : 255;   // narrow span forces matches
         sorted_order = ($urandom_range(0, 3) != 0);
         first_plan.delete();
         second_plan.delete();
         repeat (n_first)  first_plan.push_back(random_power(span));
         repeat (n_second) second_plan.push_back(random_power(span));
         if (sorted_order) begin
            first_plan.rsort();
            second_plan.rsort();
         end

         // loads of the two lists interleave at random, each list keeps its order
         while (first_plan.size() + second_plan.size() != 0) begin
            if (second_plan.size() == 0 ||
                (first_plan.size() != 0 && $urandom_range(0, 1) == 0))
               send_command(command_word(OP_LOAD_FIRST, random_coef(), first_plan.pop_front()));
            else
               send_command(command_word(OP_LOAD_SECOND, random_coef(), second_plan.pop_front()));
         end

         n_ops = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
         repeat (n_ops) begin
            if ($urandom_range(0, 9) == 0)
               send_command(command_word(($urandom_range(0, 1) == 0) ? OP_UNUSED_LO
                                                                     : OP_UNUSED_HI,
                                         random_coef(), random_power(255)));
            case ($urandom_range(0, 2))
               0:       op_pick = OP_ADD;
               1:       op_pick = OP_SUB;
               default: op_pick = OP_MUL;
            endcase
            send_command(command_word(op_pick, random_coef(), random_power(255)));
         end

         if ($urandom_range(0, 5) == 0)
            drain_results();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d loads (%0d dropped on a full list), %0d add, %0d subtract, %0d multiply",
               sb.load_count, sb.dropped_count, sb.add_count, sb.sub_count, sb.mul_count);
      $display("plus %0d clears and %0d unused codes; %0d result words checked, %0d empty results",
               sb.clear_count, sb.ignored_count, sb.word_count, sb.empty_count);
      if (sb.error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
